// File: design/bblur_pkg.sv
// Shared types and constants for the 3x3 box blur block.
// Used by the controller, the datapath and the top level; no dependencies.

package bblur_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 12;
	localparam int ROW_W      = 12;
	// Input row counter runs two rows past the last row while the pipe drains.
	localparam int IN_ROW_W   = ROW_W + 1;
	localparam int SUM_W      = 12;
	localparam int RECIP_W    = 17;
	localparam int RECIP_SHIFT = 16;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

	// Red sits in the lowest byte, so the struct maps straight onto tdata.
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	typedef struct packed {
		logic take;
		logic shift;
		logic sum;
		logic load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic frame_in_done;
		logic emit;
		logic out_free;
	} dp_status_t;

	// Fixed-point reciprocal of the neighbour count, scaled by 2^RECIP_SHIFT and
	// rounded up. Exact floor division for every sum a 3x3 window can reach.
	function automatic logic [RECIP_W-1:0] recip(input logic [3:0] divisor);
		logic [RECIP_W-1:0] r;
		unique case (divisor)
			4'd2:    r = 17'd32768;
			4'd3:    r = 17'd21846;
			4'd4:    r = 17'd16384;
			4'd6:    r = 17'd10923;
			4'd9:    r = 17'd7282;
			default: r = 17'd65536;
		endcase
		return r;
	endfunction

endpackage

// File: design/bblur_ram.sv
// Generic simple dual-port RAM with a registered read port.
// No dependencies; used for the two line stores of the box blur.

module bblur_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/bblur_ctrl.sv
// Sequencing state machine for the box blur: input handshake and step commands.
// Depends on bblur_pkg for the command and status structs.

module bblur_ctrl
	import bblur_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic       s_axis_tuser,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SHIFT = 2'd1;
	localparam logic [1:0] ST_SUM   = 2'd2;
	localparam logic [1:0] ST_MUL   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;
	logic       skip;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	// A flush that arrives while frame pixels are still expected does nothing.
	assign skip          = s_axis_tuser && !status.frame_in_done;

	always_comb begin
		cmd       = '0;
		cmd.take  = accept;
		cmd.shift = (state_q == ST_SHIFT);
		cmd.sum   = (state_q == ST_SUM);
		cmd.load  = (state_q == ST_MUL) && status.out_free;
		state_d   = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !skip) begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				state_d = status.emit ? ST_SUM : ST_IDLE;
			end
			ST_SUM: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: design/bblur_dp.sv
// Datapath of the box blur: line stores, 3x3 window, position counters,
// masked sums, reciprocal multiply and output register. Uses bblur_pkg and bblur_ram.

module bblur_dp
	import bblur_pkg::*;
#(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_cmd_t             cmd,
	output dp_status_t            status,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic [23:0]           s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [31:0]           m_axis_tdata,
	output logic                  m_axis_tlast
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int CW1 = CW + 1;
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int WIDTH_RST  = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
	localparam int HEIGHT_RST = 480;

	logic [WW-1:0]       width_q;
	logic [ROW_W-1:0]    height_q;
	logic [CW-1:0]       in_col_q;
	logic [IN_ROW_W-1:0] in_row_q;
	logic [CW-1:0]       out_col_q;
	logic [ROW_W-1:0]    out_row_q;
	pixel_t              pix_q;
	pixel_t              win_q [3][3];
	pixel_t              upper_rd;
	pixel_t              middle_rd;
	logic                out_valid_q;
	pixel_t              out_px_q;
	logic                out_last_q;
	logic [SUM_W-1:0]    sum_r_s1;
	logic [SUM_W-1:0]    sum_g_s1;
	logic [SUM_W-1:0]    sum_b_s1;
	logic [RECIP_W-1:0]  recip_s1;
	logic                last_s1;

	logic                restart;
	logic                in_col_wrap;
	logic                use_l;
	logic                use_r;
	logic                use_t;
	logic                use_b;
	logic [2:0]          col_use;
	logic [2:0]          row_use;
	logic [1:0]          ncols;
	logic [1:0]          nrows;
	logic [SUM_W-1:0]    sum_r;
	logic [SUM_W-1:0]    sum_g;
	logic [SUM_W-1:0]    sum_b;
	logic [SUM_W+RECIP_W-1:0] prod_r;
	logic [SUM_W+RECIP_W-1:0] prod_g;
	logic [SUM_W+RECIP_W-1:0] prod_b;

	// The RAM read port follows in_col_q all the time, so the entries for the
	// current column are already registered at the edge that accepts an item.
	bblur_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (cmd.shift),
		.waddr (in_col_q),
		.wdata (middle_rd),
		.raddr (in_col_q),
		.rdata (upper_rd)
	);

	bblur_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_middle (
		.clk   (clk),
		.we    (cmd.shift),
		.waddr (in_col_q),
		.wdata (pix_q),
		.raddr (in_col_q),
		.rdata (middle_rd)
	);

	assign restart     = cfg_we || (cmd.load && last_s1);
	assign in_col_wrap = (CW1'(in_col_q) + CW1'(1)) >= CW1'(width_q);

	assign status.frame_in_done = in_row_q >= IN_ROW_W'(height_q);
	assign status.emit = (in_row_q > IN_ROW_W'(1)) ||
		((in_row_q == IN_ROW_W'(1)) && (in_col_q != '0));
	assign status.out_free = !out_valid_q || m_axis_tready;

	// Edge masks for the result position.
	assign use_l   = (out_col_q != '0);
	assign use_r   = (CW1'(out_col_q) + CW1'(1)) < CW1'(width_q);
	assign use_t   = (out_row_q != '0);
	assign use_b   = (out_row_q + ROW_W'(1)) < height_q;
	assign col_use = {use_r, 1'b1, use_l};
	assign row_use = {use_b, 1'b1, use_t};
	assign ncols   = 2'd1 + 2'(use_l) + 2'(use_r);
	assign nrows   = 2'd1 + 2'(use_t) + 2'(use_b);

	always_comb begin
		sum_r = '0;
		sum_g = '0;
		sum_b = '0;
		for (int y = 0; y < 3; y++) begin
			for (int x = 0; x < 3; x++) begin
				if (row_use[y] && col_use[x]) begin
					sum_r = sum_r + SUM_W'(win_q[y][x].red);
					sum_g = sum_g + SUM_W'(win_q[y][x].green);
					sum_b = sum_b + SUM_W'(win_q[y][x].blue);
				end
			end
		end
	end

	assign prod_r = (SUM_W+RECIP_W)'(sum_r_s1) * (SUM_W+RECIP_W)'(recip_s1);
	assign prod_g = (SUM_W+RECIP_W)'(sum_g_s1) * (SUM_W+RECIP_W)'(recip_s1);
	assign prod_b = (SUM_W+RECIP_W)'(sum_b_s1) * (SUM_W+RECIP_W)'(recip_s1);

	// Configuration, position counters, window and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= WW'(WIDTH_RST);
			height_q    <= ROW_W'(HEIGHT_RST);
			in_col_q    <= '0;
			in_row_q    <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			out_valid_q <= 1'b0;
			for (int y = 0; y < 3; y++) begin
				for (int x = 0; x < 3; x++) begin
					win_q[y][x] <= '0;
				end
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_IMAGE_WIDTH) begin
					if (cfg_wdata == '0) begin
						width_q <= WW'(1);
					end else if (int'(cfg_wdata) > MAX_WIDTH) begin
						width_q <= WW'(MAX_WIDTH);
					end else begin
						width_q <= WW'(cfg_wdata);
					end
				end else begin
					height_q <= (cfg_wdata == '0) ? ROW_W'(1) : cfg_wdata;
				end
			end

			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			if (restart) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				for (int y = 0; y < 3; y++) begin
					for (int x = 0; x < 3; x++) begin
						win_q[y][x] <= '0;
					end
				end
			end else begin
				if (cmd.shift) begin
					for (int y = 0; y < 3; y++) begin
						win_q[y][0] <= win_q[y][1];
						win_q[y][1] <= win_q[y][2];
					end
					win_q[0][2] <= upper_rd;
					win_q[1][2] <= middle_rd;
					win_q[2][2] <= pix_q;
					if (in_col_wrap) begin
						in_col_q <= '0;
						in_row_q <= in_row_q + IN_ROW_W'(1);
					end else begin
						in_col_q <= in_col_q + CW'(1);
					end
				end
				if (cmd.load) begin
					if (!use_r) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + ROW_W'(1);
					end else begin
						out_col_q <= out_col_q + CW'(1);
					end
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			// Once all frame pixels are in, any item only drains the pipe.
			pix_q <= status.frame_in_done ? '0 : pixel_t'(s_axis_tdata);
		end
		if (cmd.sum) begin
			sum_r_s1 <= sum_r;
			sum_g_s1 <= sum_g;
			sum_b_s1 <= sum_b;
			recip_s1 <= recip(4'(ncols) * 4'(nrows));
			last_s1  <= !use_b && !use_r;
		end
		if (cmd.load) begin
			out_px_q.red   <= prod_r[RECIP_SHIFT +: 8];
			out_px_q.green <= prod_g[RECIP_SHIFT +: 8];
			out_px_q.blue  <= prod_b[RECIP_SHIFT +: 8];
			out_last_q     <= last_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {ALPHA_OPAQUE, out_px_q};
	assign m_axis_tlast  = out_last_q;

endmodule

// File: design/box_blur_3x3_rgb.sv
// Top level of the 3x3 RGB box blur: controller plus datapath.
// Depends on bblur_pkg, bblur_ctrl, bblur_dp and bblur_ram.
//
// Channel   Direction  Handshake             Payload
// s_axis    in         tvalid/tready         tdata: red, green, blue; tuser: is_flush
// m_axis    out        tvalid/tready         tdata: blur_red..blur_alpha; tlast: frame_last
// cfg       in         cfg_we (no wait)      cfg_index, cfg_wdata
//
// A flush ignored mid-frame is only accepted; an item without a result is accepted,
// then shifts the window and writes the line stores; an item with a result adds the
// masked sum and reciprocal multiply steps; the sequencer handles one item at a time.
// Results trail the input by image_width + 1 items.
// The output register lets a new item start while a result waits; a stalled
// m_axis holds the sequencer in its multiply step. Reset needs no clearing pass.

module box_blur_3x3_rgb
	import bblur_pkg::*;
#(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [23:0]           s_axis_tdata,  // red_in, green_in, blue_in
	input  logic                  s_axis_tuser,  // is_flush
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [31:0]           m_axis_tdata,  // blur_red, blur_green, blur_blue, blur_alpha
	output logic                  m_axis_tlast
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	bblur_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tuser  (s_axis_tuser),
		.status        (status),
		.cmd           (cmd)
	);

	bblur_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// File: bench/box_blur_3x3_rgb_test.sv
// Self-checking bench for the 3x3 RGB box blur: streams frames of many sizes
// through the block and compares every blurred pixel with its own predictor.
// Depends on bblur_pkg and the box_blur_3x3_rgb top level.

module box_blur_3x3_rgb_test
	import bblur_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_DEPTH    = 2048;
	localparam int RANDOM_ITEMS  = 1900;
	localparam int SETTLE_CYCLES = 12;
	localparam int CYCLE_LIMIT   = 2000000;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last;
	} blur_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [23:0]           s_axis_tdata;  // red_in, green_in, blue_in
	logic                  s_axis_tuser;  // is_flush
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [31:0]           m_axis_tdata;  // blur_red, blur_green, blur_blue, blur_alpha
	logic                  m_axis_tlast;

	// Predictor state.
	logic [11:0] frame_width;
	logic [11:0] frame_height;
	pixel_t      upper_row [LINE_DEPTH];
	pixel_t      middle_row [LINE_DEPTH];
	pixel_t      window [3][3];
	logic [11:0] in_col;
	logic [12:0] in_row;
	logic [11:0] out_col;
	logic [11:0] out_row;
	bit          frame_closed;

	blur_result_t expected_blurs [$];
	int unsigned  errors = 0;
	int unsigned  cycle_count = 0;
	int unsigned  counted_items = 0;
	bit           no_idle = 1'b0;

	box_blur_3x3_rgb dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int unsigned active_width();
		if (frame_width == 0)
			return 1;
		if (frame_width > LINE_DEPTH)
			return LINE_DEPTH;
		return frame_width;
	endfunction

	function automatic int unsigned active_height();
		return (frame_height == 0) ? 1 : frame_height;
	endfunction

	function automatic void clear_position();
		for (int y = 0; y < 3; y++)
			for (int x = 0; x < 3; x++)
				window[y][x] = '0;
		in_col  = '0;
		in_row  = '0;
		out_col = '0;
		out_row = '0;
	endfunction

	// Advances the predictor by one accepted transaction; returns 1 when it
	// yields a blurred pixel.
	function automatic bit blur_predict(input logic flush, input pixel_t px,
			output blur_result_t res);
		int unsigned w, h, col, cnt, sum_r, sum_g, sum_b;
		pixel_t      pix;
		bit          emit, use_l, use_r, use_t, use_b;
		w   = active_width();
		h   = active_height();
		pix = '0;
		res = '0;
		// Once all frame pixels are in, every item only pushes the pipe along.
		if (in_row < h) begin
			if (flush)
				return 0;
			pix = px;
		end
		emit = (in_row > 1) || (in_row == 1 && in_col >= 1);
		col  = in_col;
		for (int k = 0; k < 3; k++) begin
			window[k][0] = window[k][1];
			window[k][1] = window[k][2];
		end
		window[0][2]    = upper_row[col];
		window[1][2]    = middle_row[col];
		window[2][2]    = pix;
		upper_row[col]  = middle_row[col];
		middle_row[col] = pix;
		in_col++;
		if (in_col >= w) begin
			in_col = '0;
			in_row++;
		end
		if (!emit)
			return 0;
		use_l = out_col > 0;
		use_r = out_col + 1 < w;
		use_t = out_row > 0;
		use_b = out_row + 1 < h;
		sum_r = 0;
		sum_g = 0;
		sum_b = 0;
		cnt   = 0;
		for (int y = 0; y < 3; y++) begin
			for (int x = 0; x < 3; x++) begin
				if ((y == 0 && !use_t) || (y == 2 && !use_b) ||
						(x == 0 && !use_l) || (x == 2 && !use_r))
					continue;
				sum_r += window[y][x].red;
				sum_g += window[y][x].green;
				sum_b += window[y][x].blue;
				cnt++;
			end
		end
		if (cnt == 0)
			cnt = 1;
		res.red   = sum_r / cnt;
		res.green = sum_g / cnt;
		res.blue  = sum_b / cnt;
		res.alpha = ALPHA_OPAQUE;
		res.last  = (out_row + 1 >= h) && (out_col + 1 >= w);
		if (res.last) begin
			clear_position();
			frame_closed = 1'b1;
		end else begin
			out_col++;
			if (out_col >= w) begin
				out_col = '0;
				out_row++;
			end
		end
		return 1;
	endfunction

	function automatic int unsigned pick_gap();
		return no_idle ? 0 : $urandom_range(0, 11);
	endfunction

	function automatic logic [7:0] rand_channel();
		case ($urandom_range(0, 7))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	function automatic pixel_t make_pixel(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		pixel_t p;
		p.red   = r;
		p.green = g;
		p.blue  = b;
		return p;
	endfunction

	function automatic pixel_t rand_pixel();
		return make_pixel(rand_channel(), rand_channel(), rand_channel());
	endfunction

	task automatic send_item(input logic flush, input pixel_t px);
		int unsigned  gap;
		blur_result_t res;
		gap = pick_gap();
		@(negedge clk);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		s_axis_tuser  <= flush;
		do @(posedge clk); while (!s_axis_tready);
		if (blur_predict(flush, px, res))
			expected_blurs.push_back(res);
	endtask

	// Drops valid, waits for every expected pixel and lets an item that yields
	// nothing finish inside the block.
	task automatic quiesce();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_blurs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_IMAGE_WIDTH)
			frame_width = value;
		else
			frame_height = value;
		clear_position();
	endtask

	task automatic set_frame_size(input logic [11:0] w, input logic [11:0] h);
		quiesce();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
	endtask

	// A noisy frame scatters flushes that arrive before the frame is complete.
	task automatic send_frame(input int unsigned n_pixels, input bit noisy);
		frame_closed = 1'b0;
		for (int unsigned i = 0; i < n_pixels; i++) begin
			if (noisy && $urandom_range(0, 9) == 0)
				send_item(1'b1, rand_pixel());
			send_item(1'b0, rand_pixel());
			counted_items++;
		end
	endtask

	// A noisy drain uses pixels as well, which act as flushes here.
	task automatic drain_frame(input bit noisy);
		while (!frame_closed) begin
			send_item(!(noisy && $urandom_range(0, 3) == 0), rand_pixel());
			counted_items++;
		end
	endtask

	task automatic test_edge_divisors();
		// Corners divide by 4, edges by 6 and the center by 9.
		set_frame_size(12'd3, 12'd3);
		frame_closed = 1'b0;
		send_item(1'b0, make_pixel(8'd255, 8'd255, 8'd255));
		send_item(1'b0, make_pixel(8'd0, 8'd0, 8'd0));
		send_item(1'b0, make_pixel(8'd255, 8'd0, 8'd128));
		send_item(1'b0, make_pixel(8'd0, 8'd255, 8'd1));
		send_item(1'b1, make_pixel(8'd17, 8'd34, 8'd51));
		send_item(1'b0, make_pixel(8'd255, 8'd255, 8'd255));
		send_item(1'b0, make_pixel(8'd254, 8'd1, 8'd127));
		send_item(1'b0, make_pixel(8'd255, 8'd255, 8'd0));
		send_item(1'b0, make_pixel(8'd0, 8'd0, 8'd255));
		send_item(1'b0, make_pixel(8'd255, 8'd255, 8'd255));
		// The frame input is complete, so this colour must not show up.
		send_item(1'b0, make_pixel(8'd255, 8'd255, 8'd255));
		drain_frame(1'b0);

		set_frame_size(12'd1, 12'd1);
		frame_closed = 1'b0;
		send_item(1'b0, make_pixel(8'd255, 8'd255, 8'd255));
		drain_frame(1'b0);

		set_frame_size(12'd2, 12'd2);
		frame_closed = 1'b0;
		send_item(1'b0, make_pixel(8'd255, 8'd0, 8'd255));
		send_item(1'b0, make_pixel(8'd0, 8'd255, 8'd0));
		send_item(1'b0, make_pixel(8'd255, 8'd255, 8'd255));
		send_item(1'b0, make_pixel(8'd1, 8'd2, 8'd3));
		drain_frame(1'b0);
	endtask

	// A register write in the middle of a frame starts a fresh frame.
	task automatic test_restart_mid_frame();
		set_frame_size(12'd4, 12'd4);
		send_frame(8, 1'b0);
		quiesce();
		write_reg(REG_IMAGE_WIDTH, 12'd5);
		send_frame(20, 1'b1);
		drain_frame(1'b1);
		send_frame(7, 1'b0);
		quiesce();
		write_reg(REG_IMAGE_HEIGHT, 12'd3);
		send_frame(15, 1'b0);
		drain_frame(1'b0);
	endtask

	// Zero sizes act as one; widths past the line store act as its depth.
	task automatic test_size_extremes();
		set_frame_size(12'd0, 12'd0);
		send_frame(1, 1'b0);
		drain_frame(1'b0);
		// The first results appear only after a full clamped row plus one
		// pixel; the frame is left open and the next size write restarts it.
		set_frame_size(12'd4095, 12'd2);
		send_frame(LINE_DEPTH + 3, 1'b0);
	endtask

	task automatic test_random_frames();
		int unsigned w, h, n;
		bit          aborted;
		counted_items = 0;
		aborted       = 1'b1;
		w             = 1;
		h             = 1;
		while (counted_items < RANDOM_ITEMS) begin
			if (aborted || $urandom_range(0, 1) == 0) begin
				w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64)
					: $urandom_range(1, 8);
				h = $urandom_range(1, 6);
				set_frame_size(w, h);
			end
			no_idle = ($urandom_range(0, 4) == 0);
			n = w * h;
			if ($urandom_range(0, 7) == 0) begin
				// Cut the frame short; the next size write restarts it.
				aborted = 1'b1;
				send_frame($urandom_range(0, n - 1), 1'b1);
			end else begin
				aborted = 1'b0;
				send_frame(n, 1'b1);
				drain_frame(1'b1);
			end
		end
		no_idle = 1'b0;
	endtask

	// Output side: random stall before each transaction.
	initial begin
		int unsigned gap;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = pick_gap();
			if (gap != 0) begin
				@(negedge clk);
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			@(negedge clk);
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (m_axis_tvalid !== 1'b1);
		end
	end

	function automatic void report_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		errors++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
	endfunction

	always @(posedge clk) begin
		blur_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_blurs.size() == 0) begin
				errors++;
				$display("%0t: unexpected transaction, expected none, actual %h last %b",
					$time, m_axis_tdata, m_axis_tlast);
			end else begin
				want = expected_blurs.pop_front();
				if (m_axis_tdata[7:0] !== want.red)
					report_field("blur_red", want.red, m_axis_tdata[7:0]);
				if (m_axis_tdata[15:8] !== want.green)
					report_field("blur_green", want.green, m_axis_tdata[15:8]);
				if (m_axis_tdata[23:16] !== want.blue)
					report_field("blur_blue", want.blue, m_axis_tdata[23:16]);
				if (m_axis_tdata[31:24] !== want.alpha)
					report_field("blur_alpha", want.alpha, m_axis_tdata[31:24]);
				if (m_axis_tlast !== want.last)
					report_field("frame_last", want.last, m_axis_tlast);
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_IMAGE_WIDTH;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		frame_width   = 12'd640;
		frame_height  = 12'd480;
		frame_closed  = 1'b0;
		for (int i = 0; i < LINE_DEPTH; i++) begin
			upper_row[i]  = '0;
			middle_row[i] = '0;
		end
		clear_position();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		test_edge_divisors();
		test_restart_mid_frame();
		test_size_extremes();
		test_random_frames();

		quiesce();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: box_blur_3x3_rgb.f
design/bblur_pkg.sv
design/bblur_ram.sv
design/bblur_ctrl.sv
design/bblur_dp.sv
design/box_blur_3x3_rgb.sv
bench/box_blur_3x3_rgb_test.sv
